// File: design/hscw_pkg.sv
`default_nettype none

package hscw_pkg;

  // Walk limits
  localparam int unsigned MAX_LAYERS = 16;
  localparam int unsigned LAYER_W    = 5;
  localparam int unsigned EDGE_W     = 3;
  localparam int unsigned COORD_W    = 6;
  localparam logic [EDGE_W-1:0] EDGE_END = 3'd6;

  // Microcode addresses
  typedef logic [1:0] uc_addr_t;
  localparam uc_addr_t UC_WAIT  = 2'd0;
  localparam uc_addr_t UC_LAYER = 2'd1;
  localparam uc_addr_t UC_EDGE  = 2'd2;
  localparam uc_addr_t UC_STEP  = 2'd3;

  // Branch conditions
  typedef enum logic [1:0] {
    C_IN_VALID,
    C_LAYER_LIVE,
    C_EDGE_END,
    C_STEP_LT
  } uc_cond_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DONE,
    OP_NEXT_LAYER,
    OP_NEXT_EDGE,
    OP_ADVANCE
  } uc_op_t;

  typedef struct packed {
    uc_cond_t cond;
    uc_op_t   op_t;
    uc_addr_t tgt_t;
    uc_op_t   op_f;
    uc_addr_t tgt_f;
  } uc_word_t;

  // Control store
  function automatic uc_word_t ucode(input uc_addr_t addr);
    uc_word_t w;
    case (addr)
      UC_WAIT:  w = '{C_IN_VALID,   OP_LOAD,       UC_LAYER, OP_NOP,       UC_WAIT};
      UC_LAYER: w = '{C_LAYER_LIVE, OP_NOP,        UC_EDGE,  OP_DONE,      UC_WAIT};
      UC_EDGE:  w = '{C_EDGE_END,   OP_NEXT_LAYER, UC_LAYER, OP_NOP,       UC_STEP};
      UC_STEP:  w = '{C_STEP_LT,    OP_ADVANCE,    UC_WAIT,  OP_NEXT_EDGE, UC_LAYER};
      default:  w = '{C_IN_VALID,   OP_NOP,        UC_WAIT,  OP_NOP,       UC_WAIT};
    endcase
    return w;
  endfunction

  // Unit step per edge, modulo 64
  function automatic logic [COORD_W-1:0] step_dx(input logic [EDGE_W-1:0] e);
    logic [COORD_W-1:0] d;
    case (e)
      3'd1, 3'd2: d = 6'd63;
      3'd4, 3'd5: d = 6'd1;
      default:    d = 6'd0;
    endcase
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] step_dy(input logic [EDGE_W-1:0] e);
    logic [COORD_W-1:0] d;
    case (e)
      3'd0, 3'd1: d = 6'd63;
      3'd3, 3'd4: d = 6'd1;
      default:    d = 6'd0;
    endcase
    return d;
  endfunction

  // Edges 2, 4 and 5 are one longer than the layer number
  function automatic logic len_extra(input logic [EDGE_W-1:0] e);
    logic x;
    case (e)
      3'd2, 3'd4, 3'd5: x = 1'b1;
      default:          x = 1'b0;
    endcase
    return x;
  endfunction

endpackage

`default_nettype wire

// File: design/hex_spiral_coord_walker.sv
`default_nettype none

// Channel   | Ports                                   | Direction
// ----------+-----------------------------------------+----------
// input     | in_valid, in_ready, in_restart          | in
// result    | out_valid, out_ready, out_x, out_y,     | out
//           | out_more                                |
// config    | cfg_we, cfg_data                        | in
//
// A word takes the microcode loop (wait, layer test, edge test, step
// test); each skipped edge adds a step, layer and edge test and each layer
// change a layer and edge test. An exhausted walk takes wait, layer test.
// Synchronous active-low reset: walk at its start for one layer.
// The result sits in an output register; the next word is taken while it
// waits, and the sequencer holds on its emitting step until that is free.
module hex_spiral_coord_walker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_restart,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_x,
  output logic [5:0]      out_y,
  output logic            out_more,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_data
);

  localparam int unsigned LW = hscw_pkg::LAYER_W;
  localparam int unsigned EW = hscw_pkg::EDGE_W;
  localparam int unsigned CW = hscw_pkg::COORD_W;

  logic [LW-1:0] layer_total_r;
  logic [LW-1:0] layer_r, layer_nxt;
  logic [EW-1:0] edge_r, edge_nxt;
  logic [LW-1:0] step_r, step_nxt;
  logic [CW-1:0] cur_x_r, cur_x_nxt;
  logic [CW-1:0] cur_y_r, cur_y_nxt;
  logic [CW-1:0] lat_x_r, lat_x_nxt;
  logic [CW-1:0] lat_y_r, lat_y_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_x_r, out_x_nxt;
  logic [CW-1:0] out_y_r, out_y_nxt;
  logic          out_more_r, out_more_nxt;
  hscw_pkg::uc_addr_t upc_r, upc_nxt;

  hscw_pkg::uc_word_t cw;
  hscw_pkg::uc_op_t   op;
  logic               cond;
  logic               emits;
  logic               stall;
  logic [LW-1:0]      limit;
  logic [LW-1:0]      edge_len;
  logic [CW-1:0]      init_x;
  logic [CW-1:0]      init_y;

  // Effective layer bound and start position
  assign limit = (layer_total_r > LW'(hscw_pkg::MAX_LAYERS)) ?
                 LW'(hscw_pkg::MAX_LAYERS) : layer_total_r;
  assign init_x   = CW'(limit);
  assign init_y   = CW'(limit) - CW'(1);
  assign edge_len = layer_r + LW'(hscw_pkg::len_extra(edge_r));

  // Control word decode and branch
  always_comb begin
    cw = hscw_pkg::ucode(upc_r);
    case (cw.cond)
      hscw_pkg::C_IN_VALID:   cond = in_valid;
      hscw_pkg::C_LAYER_LIVE: cond = layer_r < limit;
      hscw_pkg::C_EDGE_END:   cond = edge_r >= hscw_pkg::EDGE_END;
      hscw_pkg::C_STEP_LT:    cond = step_r < edge_len;
      default:                cond = 1'b0;
    endcase
    op    = cond ? cw.op_t : cw.op_f;
    emits = (op == hscw_pkg::OP_DONE) || (op == hscw_pkg::OP_ADVANCE);
    stall = emits && out_valid_r && !out_ready;
  end

  assign in_ready = (upc_r == hscw_pkg::UC_WAIT);

  // Datapath
  always_comb begin
    layer_nxt     = layer_r;
    edge_nxt      = edge_r;
    step_nxt      = step_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    lat_x_nxt     = lat_x_r;
    lat_y_nxt     = lat_y_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_more_nxt  = out_more_r;
    out_valid_nxt = out_valid_r && !out_ready;
    upc_nxt       = upc_r;
    if (!stall) begin
      upc_nxt = cond ? cw.tgt_t : cw.tgt_f;
      case (op)
        hscw_pkg::OP_LOAD: begin
          if (in_restart) begin
            layer_nxt = '0;
            edge_nxt  = '0;
            step_nxt  = '0;
            cur_x_nxt = init_x;
            cur_y_nxt = init_y;
            lat_x_nxt = init_x;
            lat_y_nxt = init_y;
          end else begin
            lat_x_nxt = cur_x_r;
            lat_y_nxt = cur_y_r;
          end
        end
        hscw_pkg::OP_NEXT_LAYER: begin
          edge_nxt  = '0;
          layer_nxt = layer_r + LW'(1);
        end
        hscw_pkg::OP_NEXT_EDGE: begin
          step_nxt = '0;
          edge_nxt = edge_r + EW'(1);
        end
        hscw_pkg::OP_ADVANCE: begin
          cur_x_nxt     = cur_x_r + hscw_pkg::step_dx(edge_r);
          cur_y_nxt     = cur_y_r + hscw_pkg::step_dy(edge_r);
          step_nxt      = step_r + LW'(1);
          out_x_nxt     = lat_x_r;
          out_y_nxt     = lat_y_r;
          out_more_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
        hscw_pkg::OP_DONE: begin
          out_x_nxt     = lat_x_r;
          out_y_nxt     = lat_y_r;
          out_more_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_total_r <= LW'(1);
      layer_r       <= '0;
      edge_r        <= '0;
      step_r        <= '0;
      cur_x_r       <= CW'(1);
      cur_y_r       <= '0;
      out_valid_r   <= 1'b0;
      upc_r         <= hscw_pkg::UC_WAIT;
    end else begin
      if (cfg_we) begin
        layer_total_r <= cfg_data;
      end
      layer_r     <= layer_nxt;
      edge_r      <= edge_nxt;
      step_r      <= step_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= out_valid_nxt;
      upc_r       <= upc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lat_x_r    <= lat_x_nxt;
    lat_y_r    <= lat_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_more_r <= out_more_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_more  = out_more_r;

  // Checks
  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    edge_r <= hscw_pkg::EDGE_END)
    else $error("edge index past end-of-layer marker");

  a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
    layer_r <= LW'(hscw_pkg::MAX_LAYERS))
    else $error("layer count past maximum");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!stall && op == hscw_pkg::OP_DONE) |-> layer_r >= limit)
    else $error("walk reported exhausted with layers left");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> upc_r == $past(upc_r))
    else $error("sequencer moved while output blocked");

endmodule

`default_nettype wire
